FILE: design/grid_ray_caster_column_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid ray caster column unit
// Clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_COLUMN_UNIT_MACROS_SVH
`define GRID_RAY_CASTER_COLUMN_UNIT_MACROS_SVH

// Same-cycle implication
`define GRC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grc same-cycle check failed");

// Next-cycle implication
`define GRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grc next-cycle check failed");

`endif

FILE: design/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Constants, codes and types shared by the grid ray caster column unit.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Map geometry and walk limit
    localparam int MAP_SIZE   = 32;
    localparam int MAX_STEPS  = 64;
    localparam int MAP_AW     = $clog2(MAP_SIZE);
    localparam int CELL_N     = MAP_SIZE * MAP_SIZE;
    localparam int CELL_AW    = $clog2(CELL_N);
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int COORD_W    = MAP_AW + 2;

    // Datapath widths
    localparam int CAM_W      = 27;
    localparam int PROD_W     = 16 + CAM_W;
    localparam int RAY_W      = 28;
    localparam int SD_W       = 56;
    localparam int DIV_NW     = 40;
    localparam int DIV_DW     = 28;
    localparam int DIV_CW     = $clog2(DIV_NW);
    localparam int LH_W       = 13;
    localparam int HEIGHT_CAP = 4096;

    // Commands in s_axis_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_COLS    = 3'd6;
    localparam logic [2:0] REG_ROWS    = 3'd7;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_DIV,
        ST_RAY_MUL,
        ST_RAY_SUM,
        ST_DX_DIV,
        ST_DY_DIV,
        ST_SIDE_MUL,
        ST_STEP,
        ST_CHECK,
        ST_H_START,
        ST_H_DIV,
        ST_SPAN,
        ST_OUT
    } t_state;

endpackage

FILE: design/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/grid_ray_caster_column_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_column_unit
// Casts one ray per screen column over a square cell map (DDA walk).
// ----------------------------------------------------------------------------
// Input beats (s_axis): tuser selects the command. A write beat stores one
// map cell. A cast beat gives a column; the unit forms the ray
// from the pose registers, walks the map and returns one m_axis beat with
// the clamped wall span, the wall kind, the side crossed and a hit flag.
// A cast runs three divisions (camera x, two reciprocals), one DDA step per
// cell through the map RAM read (up to 64 steps), one more division for the
// span height, and the setup states around them. A null ray never walks; it
// returns after the camera x division. Divisions run on the shared divider,
// one quotient bit per cycle. One item is in work at a time; the next beat
// is taken once the result sits in the output register.
// Reset: the pose registers take their defaults and the map RAM is swept to
// zero, one cell a cycle, over all 1024 cells with s_axis_tready low.
// Configuration writes are taken during the sweep as ever.
// A stalled m_axis holds the result; the unit may accept write beats and one
// more cast beat, then waits with its result until the output register frees.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_column_unit_macros.svh"

module grid_ray_caster_column_unit import grc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column[9:0], cell_x[14:10], cell_y[19:15], cell_value[27:20], zero fill
    input  logic [31:0] s_axis_tdata,
    // cmd[0]
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_column[9:0], span_top[19:10], span_bottom[29:20], wall_kind[37:30],
    // hit_side[38], wall_hit[39]
    output logic [39:0] m_axis_tdata
);

    localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELL_N - 1);
    localparam logic [SD_W-1:0]    DIST_INF  = SD_W'(1) << 52;

    // Config registers
    logic [15:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0]        r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 16'd45056;
            r_pos_y   <= 16'd24576;
            r_dir_x   <= -16'sd16384;
            r_dir_y   <= 16'sd0;
            r_plane_x <= 16'sd0;
            r_plane_y <= 16'sd10813;
            r_cols    <= 11'd640;
            r_rows    <= 11'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POS_X:   r_pos_x   <= i_cfg_data;
                REG_POS_Y:   r_pos_y   <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data;
                REG_DIR_Y:   r_dir_y   <= i_cfg_data;
                REG_PLANE_X: r_plane_x <= i_cfg_data;
                REG_PLANE_Y: r_plane_y <= i_cfg_data;
                REG_COLS:    r_cols    <= i_cfg_data[10:0];
                REG_ROWS:    r_rows    <= i_cfg_data[10:0];
                default:     r_rows    <= r_rows;
            endcase
        end
    end

    // Effective screen size, zero acts as one
    logic [10:0] w_cols, w_rows;
    assign w_cols = (r_cols == 11'd0) ? 11'd1 : r_cols;
    assign w_rows = (r_rows == 11'd0) ? 11'd1 : r_rows;

    // Input fields
    logic [9:0] w_in_col;
    logic [4:0] w_in_cx, w_in_cy;
    logic [7:0] w_in_val;
    assign w_in_col = s_axis_tdata[9:0];
    assign w_in_cx  = s_axis_tdata[14:10];
    assign w_in_cy  = s_axis_tdata[19:15];
    assign w_in_val = s_axis_tdata[27:20];

    // State and datapath registers
    t_state                    r_state, n_state;
    logic [CELL_AW-1:0]        r_clr, n_clr;
    logic [9:0]                r_col, n_col;
    logic signed [CAM_W-1:0]   r_cam, n_cam;
    logic signed [PROD_W-1:0]  r_prx, n_prx, r_pry, n_pry;
    logic signed [RAY_W-1:0]   r_rx, n_rx, r_ry, n_ry;
    logic [SD_W-1:0]           r_dx, n_dx, r_dy, n_dy, r_sdx, n_sdx, r_sdy, n_sdy;
    logic signed [COORD_W-1:0] r_mx, n_mx, r_my, n_my;
    logic                      r_side, n_side, r_hit, n_hit;
    logic [STEP_W-1:0]         r_steps, n_steps;
    logic [7:0]                r_kind, n_kind;
    logic [LH_W-1:0]           r_lh, n_lh;
    logic [9:0]                r_top, n_top, r_bot, n_bot;
    logic                      r_o_valid, n_o_valid;
    logic [39:0]               r_o_data, n_o_data;

    // Shared restoring divider, one quotient bit per cycle
    logic                      r_dv_busy;
    logic [DIV_CW-1:0]         r_dv_cnt;
    logic [DIV_DW:0]           r_dv_rem;
    logic [DIV_NW-1:0]         r_dv_quo;
    logic [DIV_DW-1:0]         r_dv_den;
    logic                      w_dv_start;
    logic [DIV_NW-1:0]         w_dv_num;
    logic [DIV_DW-1:0]         w_dv_den;
    logic [DIV_DW:0]           w_dv_sh;
    logic                      w_dv_ge;

    assign w_dv_sh = {r_dv_rem[DIV_DW-1:0], r_dv_quo[DIV_NW-1]};
    assign w_dv_ge = (w_dv_sh >= {1'b0, r_dv_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (w_dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= '0;
        end else if (r_dv_busy) begin
            r_dv_cnt <= r_dv_cnt + 1'b1;
            if (r_dv_cnt == DIV_CW'(DIV_NW - 1)) begin
                r_dv_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_start) begin
            r_dv_rem <= '0;
            r_dv_quo <= w_dv_num;
            r_dv_den <= w_dv_den;
        end else if (r_dv_busy) begin
            r_dv_rem <= w_dv_ge ? (w_dv_sh - {1'b0, r_dv_den}) : w_dv_sh;
            r_dv_quo <= {r_dv_quo[DIV_NW-2:0], w_dv_ge};
        end
    end

    // Map RAM
    logic               w_ram_we;
    logic [CELL_AW-1:0] w_ram_waddr, w_ram_raddr;
    logic [7:0]         w_ram_wdata, w_ram_rdata;

    grc_ram #(
        .WIDTH (8),
        .DEPTH (CELL_N)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Handshakes
    logic w_in_acc;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    // Combinational helpers
    logic signed [12:0]        w_cam_n;
    logic [12:0]               w_cam_mag;
    logic signed [RAY_W-1:0]   w_rx, w_ry;
    logic [RAY_W-1:0]          w_ax, w_ay, w_rax, w_ray;
    logic [11:0]               w_fx, w_fy;
    logic [42:0]               w_sx_prod, w_sy_prod;
    logic signed [COORD_W-1:0] w_smx, w_smy;
    logic                      w_lt, w_exit;
    logic signed [18:0]        w_num;
    logic [18:0]               w_an;
    logic [DIV_NW-1:0]         w_hnum;
    logic signed [13:0]        w_top, w_bot;

    assign w_cam_n   = 13'(signed'({1'b0, w_in_col, 1'b0})) - 13'(signed'({2'b0, w_cols}));
    assign w_cam_mag = w_cam_n[12] ? 13'(-w_cam_n) : 13'(w_cam_n);
    assign w_rx      = RAY_W'(r_dir_x) + RAY_W'(r_prx >>> 14);
    assign w_ry      = RAY_W'(r_dir_y) + RAY_W'(r_pry >>> 14);
    assign w_ax      = r_rx[RAY_W-1] ? RAY_W'(-r_rx) : RAY_W'(r_rx);
    assign w_ay      = r_ry[RAY_W-1] ? RAY_W'(-r_ry) : RAY_W'(r_ry);
    assign w_rax     = w_rx[RAY_W-1] ? RAY_W'(-w_rx) : RAY_W'(w_rx);
    assign w_ray     = w_ry[RAY_W-1] ? RAY_W'(-w_ry) : RAY_W'(w_ry);
    assign w_fx      = r_rx[RAY_W-1] ? {1'b0, r_pos_x[10:0]} : 12'd2048 - {1'b0, r_pos_x[10:0]};
    assign w_fy      = r_ry[RAY_W-1] ? {1'b0, r_pos_y[10:0]} : 12'd2048 - {1'b0, r_pos_y[10:0]};
    assign w_sx_prod = 43'(w_fx) * 43'(r_dx[30:0]);
    assign w_sy_prod = 43'(w_fy) * 43'(r_dy[30:0]);

    // Next DDA step: y advances on a tie
    assign w_lt   = (r_sdx < r_sdy);
    assign w_smx  = w_lt ? (r_mx + (r_rx[RAY_W-1] ? -COORD_W'(1) : COORD_W'(1))) : r_mx;
    assign w_smy  = w_lt ? r_my : (r_my + (r_ry[RAY_W-1] ? -COORD_W'(1) : COORD_W'(1)));
    assign w_exit = w_smx[COORD_W-1] || w_smy[COORD_W-1]
                 || (w_smx >= COORD_W'(MAP_SIZE)) || (w_smy >= COORD_W'(MAP_SIZE));
    assign w_ram_raddr = CELL_AW'(w_smx[COORD_W-2:0]) * CELL_AW'(MAP_SIZE)
                       + CELL_AW'(w_smy[COORD_W-2:0]);

    // Boundary distance and height dividend
    assign w_num  = r_side
                  ? (19'(r_my) * 19'sd2048 - 19'(signed'({1'b0, r_pos_y}))
                     + (r_ry[RAY_W-1] ? 19'sd2048 : 19'sd0))
                  : (19'(r_mx) * 19'sd2048 - 19'(signed'({1'b0, r_pos_x}))
                     + (r_rx[RAY_W-1] ? 19'sd2048 : 19'sd0));
    assign w_an   = w_num[18] ? 19'(-w_num) : 19'(w_num);
    assign w_hnum = DIV_NW'(w_rows) * DIV_NW'(r_side ? w_ay : w_ax);

    // Span around the screen center
    assign w_top = 14'(signed'({1'b0, w_rows[10:1]})) - 14'(signed'({1'b0, r_lh[LH_W-1:1]}));
    assign w_bot = 14'(signed'({1'b0, w_rows[10:1]})) + 14'(signed'({1'b0, r_lh[LH_W-1:1]}));

    // State register and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_cam    <= n_cam;
        r_prx    <= n_prx;
        r_pry    <= n_pry;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sdx    <= n_sdx;
        r_sdy    <= n_sdy;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_side   <= n_side;
        r_hit    <= n_hit;
        r_steps  <= n_steps;
        r_kind   <= n_kind;
        r_lh     <= n_lh;
        r_top    <= n_top;
        r_bot    <= n_bot;
        r_o_data <= n_o_data;
    end

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_col       = r_col;
        n_cam       = r_cam;
        n_prx       = r_prx;
        n_pry       = r_pry;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sdx       = r_sdx;
        n_sdy       = r_sdy;
        n_mx        = r_mx;
        n_my        = r_my;
        n_side      = r_side;
        n_hit       = r_hit;
        n_steps     = r_steps;
        n_kind      = r_kind;
        n_lh        = r_lh;
        n_top       = r_top;
        n_bot       = r_bot;
        n_o_data    = r_o_data;
        n_o_valid   = r_o_valid && !m_axis_tready;
        w_dv_start  = 1'b0;
        w_dv_num    = '0;
        w_dv_den    = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr;
        w_ram_wdata = 8'd0;

        case (r_state)
            // Sweep the map to zero after reset
            ST_CLEAR: begin
                w_ram_we = 1'b1;
                n_clr    = r_clr + 1'b1;
                if (r_clr == CELL_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            // Take a beat: write a cell, or start a cast with camera x
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == CMD_WRITE) begin
                        w_ram_we    = (32'(w_in_cx) < MAP_SIZE) && (32'(w_in_cy) < MAP_SIZE);
                        w_ram_waddr = CELL_AW'(w_in_cx) * CELL_AW'(MAP_SIZE) + CELL_AW'(w_in_cy);
                        w_ram_wdata = w_in_val;
                    end else begin
                        n_col      = w_in_col;
                        n_hit      = 1'b0;
                        n_cam      = w_cam_n[12] ? -CAM_W'(1) : CAM_W'(0);
                        w_dv_start = 1'b1;
                        w_dv_num   = DIV_NW'(w_cam_mag) << 14;
                        w_dv_den   = DIV_DW'(w_cols);
                        n_state    = ST_CAM_DIV;
                    end
                end
            end
            // Camera x, truncated toward zero
            ST_CAM_DIV: begin
                if (!r_dv_busy) begin
                    n_cam   = r_cam[CAM_W-1] ? -CAM_W'(r_dv_quo) : CAM_W'(r_dv_quo);
                    n_state = ST_RAY_MUL;
                end
            end
            ST_RAY_MUL: begin
                n_prx   = PROD_W'(r_plane_x) * PROD_W'(r_cam);
                n_pry   = PROD_W'(r_plane_y) * PROD_W'(r_cam);
                n_state = ST_RAY_SUM;
            end
            // Ray, start cell, and the x reciprocal
            ST_RAY_SUM: begin
                n_rx = w_rx;
                n_ry = w_ry;
                n_mx = COORD_W'(r_pos_x[15:11]);
                n_my = COORD_W'(r_pos_y[15:11]);
                if (((w_rx == '0) && (w_ry == '0))
                        || (32'(r_pos_x[15:11]) >= MAP_SIZE)
                        || (32'(r_pos_y[15:11]) >= MAP_SIZE)) begin
                    n_state = ST_OUT;
                end else begin
                    w_dv_start = 1'b1;
                    w_dv_num   = DIV_NW'(1) << 30;
                    w_dv_den   = w_rax;
                    n_state    = ST_DX_DIV;
                end
            end
            ST_DX_DIV: begin
                if (!r_dv_busy) begin
                    n_dx       = (w_ax == '0) ? DIST_INF : SD_W'(r_dv_quo);
                    w_dv_start = 1'b1;
                    w_dv_num   = DIV_NW'(1) << 30;
                    w_dv_den   = w_ay;
                    n_state    = ST_DY_DIV;
                end
            end
            ST_DY_DIV: begin
                if (!r_dv_busy) begin
                    n_dy    = (w_ay == '0) ? DIST_INF : SD_W'(r_dv_quo);
                    n_state = ST_SIDE_MUL;
                end
            end
            // Initial side distances
            ST_SIDE_MUL: begin
                n_sdx   = (w_ax == '0) ? (SD_W'(w_fx) << 41) : SD_W'(w_sx_prod >> 11);
                n_sdy   = (w_ay == '0) ? (SD_W'(w_fy) << 41) : SD_W'(w_sy_prod >> 11);
                n_steps = '0;
                n_state = ST_STEP;
            end
            // Advance one cell and issue its read
            ST_STEP: begin
                n_mx    = w_smx;
                n_my    = w_smy;
                n_side  = !w_lt;
                n_steps = r_steps + 1'b1;
                if (w_lt) begin
                    n_sdx = r_sdx + r_dx;
                end else begin
                    n_sdy = r_sdy + r_dy;
                end
                n_state = w_exit ? ST_OUT : ST_CHECK;
            end
            // Test the cell just read
            ST_CHECK: begin
                if (w_ram_rdata != 8'd0) begin
                    n_hit   = 1'b1;
                    n_kind  = w_ram_rdata;
                    n_state = ST_H_START;
                end else if (r_steps == STEP_W'(MAX_STEPS)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_STEP;
                end
            end
            // Line height: rows * |ray| / (8 * distance)
            ST_H_START: begin
                if (w_an == '0) begin
                    n_lh    = LH_W'(HEIGHT_CAP);
                    n_state = ST_SPAN;
                end else begin
                    w_dv_start = 1'b1;
                    w_dv_num   = w_hnum;
                    w_dv_den   = DIV_DW'(w_an) << 3;
                    n_state    = ST_H_DIV;
                end
            end
            ST_H_DIV: begin
                if (!r_dv_busy) begin
                    n_lh    = (r_dv_quo > DIV_NW'(HEIGHT_CAP)) ? LH_W'(HEIGHT_CAP)
                                                              : LH_W'(r_dv_quo);
                    n_state = ST_SPAN;
                end
            end
            // Clamp the span to the screen
            ST_SPAN: begin
                n_top   = w_top[13] ? 10'd0 : w_top[9:0];
                n_bot   = (w_bot >= 14'(signed'({3'b0, w_rows})))
                        ? 10'(w_rows - 11'd1) : w_bot[9:0];
                n_state = ST_OUT;
            end
            // Hand the result to the output register once it frees
            ST_OUT: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {r_hit, r_hit & r_side,
                                 r_hit ? r_kind : 8'd0,
                                 r_hit ? r_bot : 10'd0,
                                 r_hit ? r_top : 10'd0,
                                 r_col};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks
    `GRC_ASSERT_IMPL(a_nohit_empty, m_axis_tvalid && !m_axis_tdata[39],
        m_axis_tdata[38:10] == 29'd0)
    `GRC_ASSERT_NEXT(a_check_next, r_state == ST_CHECK,
        r_state == ST_STEP || r_state == ST_H_START || r_state == ST_OUT)
    `GRC_ASSERT_IMPL(a_step_bound, r_state == ST_STEP || r_state == ST_CHECK,
        r_steps <= STEP_W'(MAX_STEPS))
    `GRC_ASSERT_IMPL(a_div_wait, r_dv_busy && r_state != ST_IDLE,
        r_state == ST_CAM_DIV || r_state == ST_DX_DIV || r_state == ST_DY_DIV
        || r_state == ST_H_DIV)

endmodule
